// ===== rtl/rsa_pkg.sv =====
// rsa_pkg: shared types and constants of the RPN stack ALU.
// Used by every file in rtl/. Depends on nothing.
package rsa_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int WORD_W      = 32;
   localparam int OPCODE_W    = 3;
   localparam int STATUS_W    = 3;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int STEP_W      = $clog2(WORD_W);

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4,
      OP_DUP  = 3'd5,
      OP_SWAP = 3'd6,
      OP_PEEK = 3'd7
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 3'd0,
      ST_FEW   = 3'd1,
      ST_OVER  = 3'd2,
      ST_UNDER = 3'd3,
      ST_DIVZ  = 3'd4,
      ST_EMPTY = 3'd5,
      ST_FULL  = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD_X,
      S_RD_Y,
      S_LOAD_Y,
      S_DUP_WR,
      S_SWAP_HI,
      S_SWAP_LO,
      S_ALU_START,
      S_ALU_WAIT,
      S_RD_TOP,
      S_TOP_WAIT,
      S_FINISH
   } seq_state_type;

   typedef enum logic [2:0] {
      ALU_IDLE,
      ALU_ADD,
      ALU_MUL,
      ALU_DIV,
      ALU_FIN,
      ALU_DONE
   } alu_state_type;

   typedef struct packed {
      logic       start;
      opcode_type op;
   } alu_cmd_type;

   typedef struct packed {
      logic       done;
      status_type status;
   } alu_rsp_type;

endpackage

// ===== rtl/rsa_channel_if.sv =====
// rsa_channel_if: valid/ready channels for requests and responses.
// Depends on rsa_pkg for field widths.
interface rsa_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [rsa_pkg::OPCODE_W-1:0]         opcode;
   logic signed [rsa_pkg::WORD_W-1:0]    push_value;

   modport source (output valid, output opcode, output push_value, input ready);
   modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface rsa_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [rsa_pkg::STATUS_W-1:0]         status;
   logic signed [rsa_pkg::WORD_W-1:0]    top_value;
   logic [rsa_pkg::COUNT_W-1:0]          entry_count;

   modport source (output valid, output status, output top_value, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input top_value, input entry_count,
                   output ready);
endinterface

// ===== rtl/rpn_stack_alu_core.sv =====
// rpn_stack_alu_core: top level of the RPN stack calculator engine.
// Depends on rsa_pkg, rsa_channel_if, rsa_stack_mem and rsa_alu_unit.
//
// Usage:
//  - req_chan carries one command per transfer: opcode and push_value
//    (push_value matters for push only). Binary ops use top as x and the
//    entry below as y, and push y op x.
//  - rsp_chan returns exactly one response per command: status, the new
//    top of stack (zero when empty) and the new entry count.
//  - One command at a time; req_chan.ready is high only while the
//    sequencer is idle. Mul and div run on the shared ALU, one bit per
//    cycle over 32 steps.
//  - Every command ends with a read of the new top from the stack RAM
//    (one read port, registered data).
//  - The response sits in an output register; a new command is accepted
//    while it waits. If the receiver stalls, the next command runs to its
//    end and holds until the response register frees up.
//  - Synchronous active-high reset empties the stack (count to zero) and
//    drops any pending response. RAM contents are left as they are.
module rpn_stack_alu_core (
   input  logic       clock,
   input  logic       reset,
   rsa_req_if.sink    req_chan,
   rsa_rsp_if.source  rsp_chan
);

   localparam int W = rsa_pkg::WORD_W;
   localparam int A = rsa_pkg::ADDR_W;
   localparam int C = rsa_pkg::COUNT_W;
   localparam logic [C-1:0] DEPTH_COUNT = C'(rsa_pkg::STACK_DEPTH);

   // sequencer state
   rsa_pkg::seq_state_type  state_ff, state_in;
   rsa_pkg::opcode_type     op_ff, op_in;
   rsa_pkg::status_type     status_ff, status_in;
   logic [C-1:0]            cnt_ff, cnt_in;
   logic [W-1:0]            x_ff, x_in;
   logic [W-1:0]            y_ff, y_in;
   logic [W-1:0]            top_ff, top_in;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   rsa_pkg::status_type     rsp_status_ff, rsp_status_in;
   logic [W-1:0]            rsp_top_ff, rsp_top_in;
   logic [C-1:0]            rsp_count_ff, rsp_count_in;

   // RAM and ALU hookup
   logic                    wr_en;
   logic [A-1:0]            wr_addr, rd_addr;
   logic [W-1:0]            wr_data, rd_data;
   rsa_pkg::alu_cmd_type    alu_cmd;
   rsa_pkg::alu_rsp_type    alu_rsp;
   logic [W-1:0]            alu_result;

   logic [C-1:0]            cnt_m1, cnt_m2;
   rsa_pkg::opcode_type     req_op;
   logic                    is_empty, is_full, too_few;

   assign cnt_m1   = cnt_ff - C'(1);
   assign cnt_m2   = cnt_ff - C'(2);
   assign req_op   = rsa_pkg::opcode_type'(req_chan.opcode);
   assign is_empty = (cnt_ff == '0);
   assign is_full  = (cnt_ff >= DEPTH_COUNT);
   assign too_few  = (cnt_ff < C'(2));

   rsa_stack_mem u_stack_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rsa_alu_unit u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (alu_cmd),
      .y_word (y_ff),
      .x_word (x_ff),
      .rsp    (alu_rsp),
      .result (alu_result)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      status_in     = status_ff;
      cnt_in        = cnt_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      top_in        = top_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = cnt_ff[A-1:0];
      wr_data       = req_chan.push_value;
      rd_addr       = cnt_m1[A-1:0];
      alu_cmd.start = 1'b0;
      alu_cmd.op    = op_ff;

      unique case (state_ff)
         rsa_pkg::S_IDLE: begin
            if (req_chan.valid) begin
               op_in     = req_op;
               status_in = rsa_pkg::ST_OK;
               state_in  = rsa_pkg::S_RD_TOP;
               unique case (req_op)
                  rsa_pkg::OP_PUSH: begin
                     if (is_full) begin
                        status_in = rsa_pkg::ST_FULL;
                     end else begin
                        wr_en  = 1'b1;
                        cnt_in = cnt_ff + C'(1);
                     end
                  end
                  rsa_pkg::OP_ADD, rsa_pkg::OP_SUB, rsa_pkg::OP_MUL,
                  rsa_pkg::OP_DIV, rsa_pkg::OP_SWAP: begin
                     if (too_few) begin
                        status_in = rsa_pkg::ST_FEW;
                     end else begin
                        state_in = rsa_pkg::S_RD_X;
                     end
                  end
                  rsa_pkg::OP_DUP: begin
                     if (is_empty) begin
                        status_in = rsa_pkg::ST_EMPTY;
                     end else if (is_full) begin
                        status_in = rsa_pkg::ST_FULL;
                     end else begin
                        state_in = rsa_pkg::S_RD_X;
                     end
                  end
                  rsa_pkg::OP_PEEK: begin
                     if (is_empty) begin
                        status_in = rsa_pkg::ST_EMPTY;
                     end
                  end
                  default: ;
               endcase
            end
         end
         rsa_pkg::S_RD_X: begin
            // top entry read
            rd_addr  = cnt_m1[A-1:0];
            state_in = (op_ff == rsa_pkg::OP_DUP) ? rsa_pkg::S_DUP_WR : rsa_pkg::S_RD_Y;
         end
         rsa_pkg::S_DUP_WR: begin
            wr_en    = 1'b1;
            wr_addr  = cnt_ff[A-1:0];
            wr_data  = rd_data;
            cnt_in   = cnt_ff + C'(1);
            state_in = rsa_pkg::S_RD_TOP;
         end
         rsa_pkg::S_RD_Y: begin
            rd_addr  = cnt_m2[A-1:0];
            x_in     = rd_data;
            state_in = rsa_pkg::S_LOAD_Y;
         end
         rsa_pkg::S_LOAD_Y: begin
            y_in     = rd_data;
            state_in = (op_ff == rsa_pkg::OP_SWAP) ? rsa_pkg::S_SWAP_HI
                                                   : rsa_pkg::S_ALU_START;
         end
         rsa_pkg::S_SWAP_HI: begin
            wr_en    = 1'b1;
            wr_addr  = cnt_m1[A-1:0];
            wr_data  = y_ff;
            state_in = rsa_pkg::S_SWAP_LO;
         end
         rsa_pkg::S_SWAP_LO: begin
            wr_en    = 1'b1;
            wr_addr  = cnt_m2[A-1:0];
            wr_data  = x_ff;
            state_in = rsa_pkg::S_RD_TOP;
         end
         rsa_pkg::S_ALU_START: begin
            // both operands are consumed whatever the outcome
            alu_cmd.start = 1'b1;
            cnt_in        = cnt_m2;
            state_in      = rsa_pkg::S_ALU_WAIT;
         end
         rsa_pkg::S_ALU_WAIT: begin
            if (alu_rsp.done) begin
               status_in = alu_rsp.status;
               if (alu_rsp.status == rsa_pkg::ST_OK) begin
                  wr_en   = 1'b1;
                  wr_addr = cnt_ff[A-1:0];
                  wr_data = alu_result;
                  cnt_in  = cnt_ff + C'(1);
               end
               state_in = rsa_pkg::S_RD_TOP;
            end
         end
         rsa_pkg::S_RD_TOP: begin
            // address wraps when empty; the data is masked below
            rd_addr  = cnt_m1[A-1:0];
            state_in = rsa_pkg::S_TOP_WAIT;
         end
         rsa_pkg::S_TOP_WAIT: begin
            top_in   = is_empty ? '0 : rd_data;
            state_in = rsa_pkg::S_FINISH;
         end
         rsa_pkg::S_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_top_in    = top_ff;
               rsp_count_in  = cnt_ff;
               state_in      = rsa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rsa_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsa_pkg::S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      status_ff     <= status_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      top_ff        <= top_in;
      rsp_status_ff <= rsp_status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_chan.ready       = (state_ff == rsa_pkg::S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.top_value   = rsp_top_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

endmodule

// ===== rtl/rsa_stack_mem.sv =====
// rsa_stack_mem: stack storage, one write port, one read port with registered data.
// Depends on rsa_pkg for depth and word width.
module rsa_stack_mem (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [rsa_pkg::ADDR_W-1:0]   wr_addr,
   input  logic [rsa_pkg::WORD_W-1:0]   wr_data,
   input  logic [rsa_pkg::ADDR_W-1:0]   rd_addr,
   output logic [rsa_pkg::WORD_W-1:0]   rd_data
);

   logic [rsa_pkg::WORD_W-1:0] store_ff [rsa_pkg::STACK_DEPTH];
   logic [rsa_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rsa_alu_unit.sv =====
// rsa_alu_unit: shared 33-bit adder driven as add/sub, shift-add multiplier
// and restoring divider, one bit per cycle. Depends on rsa_pkg.
module rsa_alu_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  rsa_pkg::alu_cmd_type         cmd,
   input  logic [rsa_pkg::WORD_W-1:0]   y_word,
   input  logic [rsa_pkg::WORD_W-1:0]   x_word,
   output rsa_pkg::alu_rsp_type         rsp,
   output logic [rsa_pkg::WORD_W-1:0]   result
);

   localparam int W = rsa_pkg::WORD_W;
   localparam logic [rsa_pkg::STEP_W-1:0] STEP_LAST = rsa_pkg::STEP_W'(W - 1);

   rsa_pkg::alu_state_type      state_ff, state_in;
   rsa_pkg::opcode_type         op_ff, op_in;
   rsa_pkg::status_type         status_ff, status_in;
   logic [W-1:0]                a_ff, a_in;      // product high / remainder
   logic [W-1:0]                b_ff, b_in;      // multiplicand / divisor magnitude
   logic [W-1:0]                q_ff, q_in;      // multiplier -> product low / quotient
   logic [W-1:0]                result_ff, result_in;
   logic [rsa_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                        neg_ff, neg_in;

   logic [W:0]                  opa, opb;
   logic                        cin;
   logic [W+1:0]                sum;
   logic [W-1:0]                y_mag, x_mag, q_neg;
   logic                        too_big, ge;

   assign y_mag = y_word[W-1] ? (~y_word + W'(1)) : y_word;
   assign x_mag = x_word[W-1] ? (~x_word + W'(1)) : x_word;
   assign q_neg = ~q_ff + W'(1);

   // the one adder, steered by state
   always_comb begin
      opa = '0;
      opb = '0;
      cin = 1'b0;
      unique case (state_ff)
         rsa_pkg::ALU_ADD: begin
            opa = {y_word[W-1], y_word};
            if (op_ff == rsa_pkg::OP_SUB) begin
               opb = ~{x_word[W-1], x_word};
               cin = 1'b1;
            end else begin
               opb = {x_word[W-1], x_word};
            end
         end
         rsa_pkg::ALU_MUL: begin
            opa = {1'b0, a_ff};
            opb = q_ff[0] ? {1'b0, b_ff} : '0;
         end
         rsa_pkg::ALU_DIV: begin
            opa = {a_ff, q_ff[W-1]};
            opb = ~{1'b0, b_ff};
            cin = 1'b1;
         end
         default: ;
      endcase
      sum = {1'b0, opa} + {1'b0, opb} + {{(W + 1){1'b0}}, cin};
   end

   assign ge = sum[W+1];

   // magnitude out of range after the last step
   always_comb begin
      if (op_ff == rsa_pkg::OP_MUL) begin
         if (neg_ff) begin
            too_big = (a_ff != '0) || (q_ff[W-1] && (q_ff[W-2:0] != '0));
         end else begin
            too_big = (a_ff != '0) || q_ff[W-1];
         end
      end else begin
         too_big = !neg_ff && q_ff[W-1];
      end
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      status_in = status_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      q_in      = q_ff;
      result_in = result_ff;
      step_in   = step_ff;
      neg_in    = neg_ff;
      unique case (state_ff)
         rsa_pkg::ALU_IDLE: begin
            if (cmd.start) begin
               op_in     = cmd.op;
               neg_in    = y_word[W-1] ^ x_word[W-1];
               status_in = rsa_pkg::ST_OK;
               result_in = '0;
               step_in   = '0;
               a_in      = '0;
               b_in      = x_mag;
               q_in      = y_mag;
               if (cmd.op == rsa_pkg::OP_MUL) begin
                  state_in = rsa_pkg::ALU_MUL;
               end else if (cmd.op == rsa_pkg::OP_DIV) begin
                  if (x_word == '0) begin
                     status_in = rsa_pkg::ST_DIVZ;
                     state_in  = rsa_pkg::ALU_DONE;
                  end else begin
                     state_in = rsa_pkg::ALU_DIV;
                  end
               end else begin
                  state_in = rsa_pkg::ALU_ADD;
               end
            end
         end
         rsa_pkg::ALU_ADD: begin
            result_in = sum[W-1:0];
            if (sum[W] != sum[W-1]) begin
               status_in = sum[W] ? rsa_pkg::ST_UNDER : rsa_pkg::ST_OVER;
            end
            state_in = rsa_pkg::ALU_DONE;
         end
         rsa_pkg::ALU_MUL: begin
            a_in    = sum[W:1];
            q_in    = {sum[0], q_ff[W-1:1]};
            step_in = step_ff + rsa_pkg::STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               state_in = rsa_pkg::ALU_FIN;
            end
         end
         rsa_pkg::ALU_DIV: begin
            a_in    = ge ? sum[W-1:0] : opa[W-1:0];
            q_in    = {q_ff[W-2:0], ge};
            step_in = step_ff + rsa_pkg::STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               state_in = rsa_pkg::ALU_FIN;
            end
         end
         rsa_pkg::ALU_FIN: begin
            result_in = neg_ff ? q_neg : q_ff;
            if (too_big) begin
               status_in = neg_ff ? rsa_pkg::ST_UNDER : rsa_pkg::ST_OVER;
            end
            state_in = rsa_pkg::ALU_DONE;
         end
         rsa_pkg::ALU_DONE: begin
            state_in = rsa_pkg::ALU_IDLE;
         end
         default: begin
            state_in = rsa_pkg::ALU_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rsa_pkg::ALU_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      status_ff <= status_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      q_ff      <= q_in;
      result_ff <= result_in;
      neg_ff    <= neg_in;
   end

   assign rsp.done   = (state_ff == rsa_pkg::ALU_DONE);
   assign rsp.status = status_ff;
   assign result     = result_ff;

endmodule
